>>> hw/rtl/spherical_to_cartesian_point_defines.svh
// assertion macros for the spherical to cartesian point block
`ifndef SPHERICAL_TO_CARTESIAN_POINT_DEFINES_SVH
`define SPHERICAL_TO_CARTESIAN_POINT_DEFINES_SVH

// consequent checked when the request in the antecedent has passed through the pipeline
`define S2C_ASSERT_AFTER(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##(s2c_pkg::LATENCY) (cons)) else $error(msg);

// consequent checked in the same cycle
`define S2C_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/s2c_pkg.sv
package s2c_pkg;

	localparam int ANGLE_STEPS_PER_DEGREE = 16;
	localparam int TRIG_FRAC_BITS = 16;
	localparam int RANGE_WIDTH = 24;
	localparam int HALF_TURN_DEG = 180;

	localparam int RANGE_IN_W = 24;
	localparam int ANGLE_W = 14;
	localparam int OUT_W = 25;

	// range bits that take part in the product
	localparam int R_W = (RANGE_WIDTH < RANGE_IN_W) ? RANGE_WIDTH : RANGE_IN_W;

	localparam int FULL_TURN = 2 * HALF_TURN_DEG * ANGLE_STEPS_PER_DEGREE;
	localparam int QUARTER = HALF_TURN_DEG * ANGLE_STEPS_PER_DEGREE / 2;

	// whole turns added so the angle is never negative
	localparam int ANG_OFFS = ((2 ** (ANGLE_W - 1) + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
	localparam int U_MAX = 2 ** (ANGLE_W - 1) - 1 + ANG_OFFS;
	localparam int U_W = $clog2(U_MAX + 1);
	localparam int QUO_W = $clog2(U_MAX / QUARTER + 1);
	localparam int T_W = $clog2(QUARTER);

	// reciprocal of the quarter turn, exact for every u below 2**U_W
	localparam int Q_SHIFT = U_W + $clog2(QUARTER);
	localparam longint unsigned Q_RECIP = ((64'd1 << Q_SHIFT) + QUARTER - 1) / QUARTER;
	localparam int RECIP_W = $clog2(Q_RECIP + 1);

	localparam int TRIG_W = TRIG_FRAC_BITS + 1;
	localparam int RCE_W = R_W + TRIG_W;
	localparam int PXY_W = RCE_W + TRIG_W;
	localparam logic [63:0] HALF_XY = 64'd1 << (2 * TRIG_FRAC_BITS - 1);
	localparam logic [63:0] HALF_Z = 64'd1 << (TRIG_FRAC_BITS - 1);

	localparam int LATENCY = 8;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	typedef struct packed {
		logic [TRIG_W-1:0] sin_mag;
		logic              sin_neg;
		logic [TRIG_W-1:0] cos_mag;
		logic              cos_neg;
	} trig_t;

	// pi in Q60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
	localparam logic [63:0] PI_DIV = 64'(HALF_TURN_DEG * ANGLE_STEPS_PER_DEGREE);
	localparam logic [63:0] PI_STEP = PI_Q60 / PI_DIV;
	localparam logic [63:0] PI_REM = PI_Q60 % PI_DIV;
	localparam logic [63:0] TRIG_HALF = 64'd1 << (59 - TRIG_FRAC_BITS);

	// series divisors, (2n)(2n+1) for the sine and (2n-1)(2n) for the cosine
	localparam logic [63:0] SIN_DIV [13] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702};
	localparam logic [63:0] COS_DIV [13] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650};

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[123:60];
	endfunction

	// quarter wave sine and cosine of one step, taylor series in Q60 then rounded
	function automatic logic [2*TRIG_W-1:0] trig_entry(input int t);
		logic [63:0] x, x2, ts, tc, ss, sc, sv, cv;
		x = PI_STEP * 64'(t) + (PI_REM * 64'(t)) / PI_DIV;
		x2 = mul_q60(x, x);
		ts = x;
		ss = x;
		tc = ONE_Q60;
		sc = ONE_Q60;
		for (int n = 1; n <= 13; n++) begin
			ts = mul_q60(ts, x2) / SIN_DIV[n-1];
			tc = mul_q60(tc, x2) / COS_DIV[n-1];
			if (n % 2 == 1) begin
				ss = ss - ts;
				sc = sc - tc;
			end else begin
				ss = ss + ts;
				sc = sc + tc;
			end
		end
		sv = (ss + TRIG_HALF) >> (60 - TRIG_FRAC_BITS);
		cv = (sc + TRIG_HALF) >> (60 - TRIG_FRAC_BITS);
		return {sv[TRIG_W-1:0], cv[TRIG_W-1:0]};
	endfunction

endpackage

>>> hw/rtl/s2c_angle.sv
module s2c_angle (
	input  logic                                clk,
	input  logic signed [s2c_pkg::ANGLE_W-1:0]  angle,
	output s2c_pkg::trig_t                      trig
);

	logic signed [s2c_pkg::U_W:0]                        u_sum;
	logic [s2c_pkg::U_W-1:0]                             u_s1;
	logic [s2c_pkg::U_W+s2c_pkg::RECIP_W-1:0]            qprod;
	logic [s2c_pkg::U_W-1:0]                             u_s2;
	logic [s2c_pkg::QUO_W-1:0]                           quo_s2;
	logic [s2c_pkg::U_W-1:0]                             base;
	logic [s2c_pkg::U_W-1:0]                             tdiff;
	logic [s2c_pkg::T_W-1:0]                             t_s3;
	s2c_pkg::quad_t                                      quad_s3;
	s2c_pkg::quad_t                                      quad_s4;
	logic [2*s2c_pkg::TRIG_W-1:0]                        trig_rom [s2c_pkg::QUARTER];
	logic [2*s2c_pkg::TRIG_W-1:0]                        rom_s4;
	logic [s2c_pkg::TRIG_W-1:0]                          s0;
	logic [s2c_pkg::TRIG_W-1:0]                          c0;
	s2c_pkg::trig_t                                      map;
	s2c_pkg::trig_t                                      trig_s5;

	// quarter-wave table, every entry fixed at elaboration
	for (genvar g = 0; g < s2c_pkg::QUARTER; g++) begin : g_rom
		localparam logic [2*s2c_pkg::TRIG_W-1:0] ENTRY = s2c_pkg::trig_entry(g);
		assign trig_rom[g] = ENTRY;
	end

	assign u_sum = (s2c_pkg::U_W + 1)'(angle) + (s2c_pkg::U_W + 1)'(s2c_pkg::ANG_OFFS);

	// total quarter turns by reciprocal multiply, quadrant is its low two bits
	assign qprod = {(s2c_pkg::RECIP_W)'(0), u_s1}
		* {(s2c_pkg::U_W)'(0), (s2c_pkg::RECIP_W)'(s2c_pkg::Q_RECIP)};

	assign base = (s2c_pkg::U_W)'(quo_s2) * (s2c_pkg::U_W)'(s2c_pkg::QUARTER);
	assign tdiff = u_s2 - base;

	assign s0 = rom_s4[2*s2c_pkg::TRIG_W-1:s2c_pkg::TRIG_W];
	assign c0 = rom_s4[s2c_pkg::TRIG_W-1:0];

	always_comb begin
		case (quad_s4)
			s2c_pkg::QUAD_I: begin
				map = '{sin_mag: s0, sin_neg: 1'b0, cos_mag: c0, cos_neg: 1'b0};
			end
			s2c_pkg::QUAD_II: begin
				map = '{sin_mag: c0, sin_neg: 1'b0, cos_mag: s0, cos_neg: 1'b1};
			end
			s2c_pkg::QUAD_III: begin
				map = '{sin_mag: s0, sin_neg: 1'b1, cos_mag: c0, cos_neg: 1'b1};
			end
			default: begin
				map = '{sin_mag: c0, sin_neg: 1'b1, cos_mag: s0, cos_neg: 1'b0};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		u_s1 <= u_sum[s2c_pkg::U_W-1:0];
		u_s2 <= u_s1;
		quo_s2 <= (s2c_pkg::QUO_W)'(qprod >> s2c_pkg::Q_SHIFT);
		t_s3 <= tdiff[s2c_pkg::T_W-1:0];
		quad_s3 <= s2c_pkg::quad_t'(quo_s2[1:0]);
		rom_s4 <= trig_rom[t_s3];
		quad_s4 <= quad_s3;
		trig_s5 <= map;
	end

	assign trig = trig_s5;

endmodule

>>> hw/rtl/spherical_to_cartesian_point.sv
// spherical to cartesian point conversion, fully pipelined
// results register together with done, which is carried by the valid chain vld_s1 to vld_s8
// throughput: one point per cycle, busy is never raised; the rate is held by splitting the
// work into angle reduction, a quarter-wave trig rom read and two chained range multiplies
// the receiver cannot stall: done marks each result for exactly one cycle
// reset clears the valid pipeline only; data registers are not reset
module spherical_to_cartesian_point (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [s2c_pkg::RANGE_IN_W-1:0]         range_dist,
	input  logic signed [s2c_pkg::ANGLE_W-1:0]     azimuth_deg,
	input  logic signed [s2c_pkg::ANGLE_W-1:0]     elevation_deg,
	output logic                                   done,
	output logic signed [s2c_pkg::OUT_W-1:0]       pos_x,
	output logic signed [s2c_pkg::OUT_W-1:0]       pos_y,
	output logic signed [s2c_pkg::OUT_W-1:0]       pos_z
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	logic [s2c_pkg::R_W-1:0]     range_s1, range_s2, range_s3, range_s4, range_s5;
	s2c_pkg::trig_t              trig_az;
	s2c_pkg::trig_t              trig_el;

	logic [s2c_pkg::RCE_W-1:0]   rce_s6;
	logic [s2c_pkg::RCE_W-1:0]   pz_s6;
	logic [s2c_pkg::TRIG_W-1:0]  ca_s6, sa_s6;
	logic                        nx_s6, ny_s6, nz_s6;

	logic [s2c_pkg::PXY_W-1:0]   px_s7, py_s7;
	logic [s2c_pkg::RCE_W-1:0]   pz_s7;
	logic                        nx_s7, ny_s7, nz_s7;

	logic [s2c_pkg::PXY_W:0]     sum_x, sum_y;
	logic [s2c_pkg::RCE_W:0]     sum_z;
	logic [s2c_pkg::OUT_W-1:0]   mag_x, mag_y, mag_z;

	logic [s2c_pkg::OUT_W-1:0]   pos_x_s8, pos_y_s8, pos_z_s8;

	assign busy = 1'b0;

	s2c_angle u_az (
		.clk   (clk),
		.angle (azimuth_deg),
		.trig  (trig_az)
	);

	s2c_angle u_el (
		.clk   (clk),
		.angle (elevation_deg),
		.trig  (trig_el)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// rounding to nearest, ties away from zero, done on the magnitude
	assign sum_x = {1'b0, px_s7} + (s2c_pkg::PXY_W + 1)'(s2c_pkg::HALF_XY);
	assign sum_y = {1'b0, py_s7} + (s2c_pkg::PXY_W + 1)'(s2c_pkg::HALF_XY);
	assign sum_z = {1'b0, pz_s7} + (s2c_pkg::RCE_W + 1)'(s2c_pkg::HALF_Z);
	assign mag_x = (s2c_pkg::OUT_W)'(sum_x >> (2 * s2c_pkg::TRIG_FRAC_BITS));
	assign mag_y = (s2c_pkg::OUT_W)'(sum_y >> (2 * s2c_pkg::TRIG_FRAC_BITS));
	assign mag_z = (s2c_pkg::OUT_W)'(sum_z >> s2c_pkg::TRIG_FRAC_BITS);

	always_ff @(posedge clk) begin
		range_s1 <= range_dist[s2c_pkg::R_W-1:0];
		range_s2 <= range_s1;
		range_s3 <= range_s2;
		range_s4 <= range_s3;
		range_s5 <= range_s4;

		rce_s6 <= {(s2c_pkg::TRIG_W)'(0), range_s5} * {(s2c_pkg::R_W)'(0), trig_el.cos_mag};
		pz_s6 <= {(s2c_pkg::TRIG_W)'(0), range_s5} * {(s2c_pkg::R_W)'(0), trig_el.sin_mag};
		ca_s6 <= trig_az.cos_mag;
		sa_s6 <= trig_az.sin_mag;
		nx_s6 <= trig_el.cos_neg ^ trig_az.cos_neg;
		ny_s6 <= trig_el.cos_neg ^ trig_az.sin_neg;
		nz_s6 <= trig_el.sin_neg;

		px_s7 <= {(s2c_pkg::TRIG_W)'(0), rce_s6} * {(s2c_pkg::RCE_W)'(0), ca_s6};
		py_s7 <= {(s2c_pkg::TRIG_W)'(0), rce_s6} * {(s2c_pkg::RCE_W)'(0), sa_s6};
		pz_s7 <= pz_s6;
		nx_s7 <= nx_s6;
		ny_s7 <= ny_s6;
		nz_s7 <= nz_s6;

		pos_x_s8 <= nx_s7 ? ((s2c_pkg::OUT_W)'(0) - mag_x) : mag_x;
		pos_y_s8 <= ny_s7 ? ((s2c_pkg::OUT_W)'(0) - mag_y) : mag_y;
		pos_z_s8 <= nz_s7 ? ((s2c_pkg::OUT_W)'(0) - mag_z) : mag_z;
	end

	assign done = vld_s8;
	assign pos_x = pos_x_s8;
	assign pos_y = pos_y_s8;
	assign pos_z = pos_z_s8;

endmodule

>>> hw/rtl/s2c_checker.sv
`include "spherical_to_cartesian_point_defines.svh"

module s2c_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [s2c_pkg::RANGE_IN_W-1:0]      range_dist,
	input logic signed [s2c_pkg::ANGLE_W-1:0]  azimuth_deg,
	input logic signed [s2c_pkg::ANGLE_W-1:0]  elevation_deg,
	input logic                                done,
	input logic signed [s2c_pkg::OUT_W-1:0]    pos_x,
	input logic signed [s2c_pkg::OUT_W-1:0]    pos_y,
	input logic signed [s2c_pkg::OUT_W-1:0]    pos_z
);

	// every request gives a result when it leaves the pipeline
	`S2C_ASSERT_AFTER(a_done_follows, start && !busy, done, "request lost in pipeline")

	// no result without a request that entered the pipeline for it
	`S2C_ASSERT_NOW(a_done_source, done, $past(start && !busy, s2c_pkg::LATENCY), "spurious result")

	`S2C_ASSERT_AFTER(a_zero_range, start && !busy && range_dist == 0, pos_x == 0 && pos_y == 0 && pos_z == 0, "zero range gave nonzero position")

	// point straight ahead lies on the x axis
	`S2C_ASSERT_AFTER(a_on_axis, start && !busy && azimuth_deg == 0 && elevation_deg == 0, pos_y == 0 && pos_z == 0, "zero angles left the x axis")

endmodule

bind spherical_to_cartesian_point s2c_checker u_s2c_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.range_dist    (range_dist),
	.azimuth_deg   (azimuth_deg),
	.elevation_deg (elevation_deg),
	.done          (done),
	.pos_x         (pos_x),
	.pos_y         (pos_y),
	.pos_z         (pos_z)
);

>>> tb/tb_spherical_to_cartesian_point.sv
module tb_spherical_to_cartesian_point;

	import s2c_pkg::*;

	localparam int FRAC = s2c_pkg::TRIG_FRAC_BITS;
	localparam int STEPS = s2c_pkg::ANGLE_STEPS_PER_DEGREE;
	localparam int FULL_STEPS = 360 * STEPS;
	localparam int QUARTER_STEPS = 90 * STEPS;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
	localparam logic [63:0] STEP_DIV = 64'(180 * STEPS);
	localparam logic [63:0] TRIG_ROUND = 64'd1 << (59 - FRAC);
	localparam int RANDOM_POINTS = 2000;
	localparam int QUIET_TAIL = 150;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [RANGE_IN_W-1:0]     r;
		logic signed [ANGLE_W-1:0] az;
		logic signed [ANGLE_W-1:0] el;
	} point_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
	} xyz_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [RANGE_IN_W-1:0]     range_dist = '0;
	logic signed [ANGLE_W-1:0] azimuth_deg = '0;
	logic signed [ANGLE_W-1:0] elevation_deg = '0;
	logic                      done;
	logic signed [OUT_W-1:0]   pos_x;
	logic signed [OUT_W-1:0]   pos_y;
	logic signed [OUT_W-1:0]   pos_z;

	logic [FRAC:0] sin_tab [QUARTER_STEPS];
	logic [FRAC:0] cos_tab [QUARTER_STEPS];

	point_t pending_points [$];
	xyz_t   expected_xyz [$];
	int     send_gap = 0;
	int     n_sent = 0;
	int     n_checked = 0;
	int     n_errors = 0;

	spherical_to_cartesian_point DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.range_dist    (range_dist),
		.azimuth_deg   (azimuth_deg),
		.elevation_deg (elevation_deg),
		.done          (done),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z)
	);

	always #6 clk = ~clk;

	// quarter-wave sine/cosine, taylor series in Q60 rounded to FRAC bits
	task automatic build_trig_table();
		logic [63:0]  x, x2, ts, tc, ss, sc;
		logic [127:0] wide;
		for (int t = 0; t < QUARTER_STEPS; t++) begin
			x = (PI_Q60 / STEP_DIV) * 64'(t) + ((PI_Q60 % STEP_DIV) * 64'(t)) / STEP_DIV;
			wide = {64'd0, x} * {64'd0, x};
			x2 = wide[123:60];
			ts = x;
			ss = x;
			tc = ONE_Q60;
			sc = ONE_Q60;
			for (int n = 1; n <= 13; n++) begin
				wide = {64'd0, ts} * {64'd0, x2};
				ts = wide[123:60] / 64'((2 * n) * (2 * n + 1));
				wide = {64'd0, tc} * {64'd0, x2};
				tc = wide[123:60] / 64'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					ss = ss - ts;
					sc = sc - tc;
				end else begin
					ss = ss + ts;
					sc = sc + tc;
				end
			end
			sin_tab[t] = (FRAC + 1)'((ss + TRIG_ROUND) >> (60 - FRAC));
			cos_tab[t] = (FRAC + 1)'((sc + TRIG_ROUND) >> (60 - FRAC));
		end
	endtask

	function automatic void angle_trig(input logic signed [ANGLE_W-1:0] ang,
			output logic [FRAC:0] s_mag, output logic s_neg,
			output logic [FRAC:0] c_mag, output logic c_neg);
		int    a;
		int    t;
		quad_t quad;
		a = int'(ang) % FULL_STEPS;
		if (a < 0)
			a += FULL_STEPS;
		quad = quad_t'(a / QUARTER_STEPS);
		t = a % QUARTER_STEPS;
		case (quad)
			QUAD_I: begin
				s_mag = sin_tab[t]; s_neg = 1'b0; c_mag = cos_tab[t]; c_neg = 1'b0;
			end
			QUAD_II: begin
				s_mag = cos_tab[t]; s_neg = 1'b0; c_mag = sin_tab[t]; c_neg = 1'b1;
			end
			QUAD_III: begin
				s_mag = sin_tab[t]; s_neg = 1'b1; c_mag = cos_tab[t]; c_neg = 1'b1;
			end
			default: begin
				s_mag = cos_tab[t]; s_neg = 1'b1; c_mag = sin_tab[t]; c_neg = 1'b0;
			end
		endcase
	endfunction

	function automatic logic signed [OUT_W-1:0] apply_sign(logic [63:0] mag, logic neg);
		return OUT_W'(neg ? (64'd0 - mag) : mag);
	endfunction

	function automatic xyz_t convert_point(logic [RANGE_IN_W-1:0] r,
			logic signed [ANGLE_W-1:0] az, logic signed [ANGLE_W-1:0] el);
		logic [FRAC:0] sa, ca, se, ce;
		logic          nsa, nca, nse, nce;
		logic [63:0]   rc;
		xyz_t          res;
		angle_trig(az, sa, nsa, ca, nca);
		angle_trig(el, se, nse, ce, nce);
		rc = 64'(r) * 64'(ce);
		res.x = apply_sign((rc * 64'(ca) + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC), nce != nca);
		res.y = apply_sign((rc * 64'(sa) + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC), nce != nsa);
		res.z = apply_sign((64'(r) * 64'(se) + (64'd1 << (FRAC - 1))) >> FRAC, nse);
		return res;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] pick_angle();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return ANGLE_W'($urandom_range(0, 2 ** ANGLE_W - 1));
		else if (sel < 80)
			// close to a quadrant boundary
			return ANGLE_W'(QUARTER_STEPS * ($urandom_range(0, 10) - 5) + $urandom_range(0, 4) - 2);
		else
			return ANGLE_W'(int'($urandom_range(0, 2 * FULL_STEPS)) - FULL_STEPS);
	endfunction

	function automatic logic [RANGE_IN_W-1:0] pick_range();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return RANGE_IN_W'($urandom_range(0, 2 ** RANGE_IN_W - 1));
		else if (sel < 85)
			return RANGE_IN_W'($urandom_range(0, 255));
		else if (sel < 92)
			return {RANGE_IN_W{1'b1}};
		else
			return RANGE_IN_W'(2 ** RANGE_IN_W - 1 - $urandom_range(0, 1023));
	endfunction

	task automatic add_point(logic [RANGE_IN_W-1:0] r, int az, int el);
		point_t p;
		p.r = r;
		p.az = ANGLE_W'(az);
		p.el = ANGLE_W'(el);
		pending_points.push_back(p);
	endtask

	// request driver
	always @(posedge clk) begin
		point_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_xyz.push_back(convert_point(range_dist, azimuth_deg, elevation_deg));
				n_sent++;
			end
			// a request still waiting keeps start and its fields
			if (!(start && busy)) begin
				if (send_gap > 0) begin
					send_gap--;
					start <= 1'b0;
				end else if (pending_points.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 16);
					start <= 1'b0;
				end else if (pending_points.size() != 0) begin
					nxt = pending_points.pop_front();
					range_dist <= nxt.r;
					azimuth_deg <= nxt.az;
					elevation_deg <= nxt.el;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		xyz_t want;
		if (arst_n && done) begin
			if (expected_xyz.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("unexpected result x=%0d y=%0d z=%0d", pos_x, pos_y, pos_z);
			end else begin
				want = expected_xyz.pop_front();
				n_checked++;
				if (pos_x !== want.x || pos_y !== want.y || pos_z !== want.z) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("point %0d: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
							n_checked, want.x, want.y, want.z, pos_x, pos_y, pos_z);
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		build_trig_table();

		// range extremes on the axes, then mid-scale ranges off the axes
		add_point(0, 0, 0);
		add_point({RANGE_IN_W{1'b1}}, 0, 0);
		add_point({RANGE_IN_W{1'b1}}, QUARTER_STEPS, 0);
		add_point({RANGE_IN_W{1'b1}}, 2 * QUARTER_STEPS, 0);
		add_point({RANGE_IN_W{1'b1}}, 3 * QUARTER_STEPS, 0);
		add_point({RANGE_IN_W{1'b1}}, FULL_STEPS, QUARTER_STEPS);
		add_point({RANGE_IN_W{1'b1}}, -FULL_STEPS, -QUARTER_STEPS);
		add_point({RANGE_IN_W{1'b1}}, -QUARTER_STEPS, 3 * QUARTER_STEPS);
		add_point(24'h800000, QUARTER_STEPS / 2, QUARTER_STEPS / 2);
		add_point(24'hAAAAAA, -QUARTER_STEPS / 2, 2 * QUARTER_STEPS);
		add_point(24'h555555, 1, -1);
		// 14-bit field ends, near full turns wrap modulo a full turn; quadrant edges
		add_point({RANGE_IN_W{1'b1}}, -(2 ** (ANGLE_W - 1)), 2 ** (ANGLE_W - 1) - 1);
		add_point({RANGE_IN_W{1'b1}}, 2 ** (ANGLE_W - 1) - 1, -(2 ** (ANGLE_W - 1)));
		add_point(24'h123456, FULL_STEPS - 1, -FULL_STEPS + 1);
		add_point(24'hFEDCBA, QUARTER_STEPS - 1, QUARTER_STEPS + 1);
		// tiny ranges with negative trig: results that round to zero come out as zero
		add_point(1, 2 * QUARTER_STEPS, 2 * QUARTER_STEPS);
		add_point(1, -1, 3 * QUARTER_STEPS + 1);
		add_point(1, 3 * QUARTER_STEPS - 5, -3);
		add_point(2, QUARTER_STEPS + 7, 2 * QUARTER_STEPS + 9);
		add_point(3, 2 * QUARTER_STEPS + 1, 2 * QUARTER_STEPS - 1);

		for (int i = 0; i < RANDOM_POINTS; i++)
			add_point(pick_range(), int'(pick_angle()), int'(pick_angle()));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_points.size() != 0 || start)
			@(posedge clk);
		while (expected_xyz.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		$display("%0d points converted and %0d results checked: range extremes, all quadrants,",
			n_sent, n_checked);
		$display("wrapped 14-bit angles and quadrant edges; %0d mismatches", n_errors);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/s2c_pkg.sv
hw/rtl/s2c_angle.sv
hw/rtl/spherical_to_cartesian_point.sv
hw/rtl/s2c_checker.sv
tb/tb_spherical_to_cartesian_point.sv
